>>> rtl/core/tdt_pkg.sv
package tdt_pkg;

  localparam int MAX_TOKEN_LENGTH = 255;
  localparam logic [7:0] LEN_CAP =
    8'((MAX_TOKEN_LENGTH < 255) ? MAX_TOKEN_LENGTH : 255);
  localparam logic [30:0] INT_CAP = 31'h7FFF_FFFF;
  localparam int KW_COUNT = 6;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_EOF   = 8'h00;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_STR  = 2'd1,
    MODE_ID   = 2'd2,
    MODE_INT  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    KIND_INVALID = 3'd0,
    KIND_EOF     = 3'd1,
    KIND_STRING  = 3'd2,
    KIND_IDENT   = 3'd3,
    KIND_INTEGER = 3'd4,
    KIND_EQUALS  = 3'd5,
    KIND_MINUS   = 3'd6,
    KIND_COMMA   = 3'd7
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [30:0] int_value;
    logic [7:0]  length;
    logic [2:0]  kw_class;
    logic        last;
  } tok_t;

  typedef struct packed {
    logic [1:0] count;
    tok_t       tok0;
    tok_t       tok1;
  } lex_out_t;

  // keywords: info, common, page, chars, char, kernings
  localparam logic [3:0] KW_LEN [KW_COUNT] = '{4'd4, 4'd6, 4'd4, 4'd5, 4'd4, 4'd8};
  localparam logic [7:0] KW_TEXT [KW_COUNT][8] = '{
    '{8'h69, 8'h6E, 8'h66, 8'h6F, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h63, 8'h6F, 8'h6D, 8'h6D, 8'h6F, 8'h6E, 8'h00, 8'h00},
    '{8'h70, 8'h61, 8'h67, 8'h65, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h63, 8'h68, 8'h61, 8'h72, 8'h73, 8'h00, 8'h00, 8'h00},
    '{8'h63, 8'h68, 8'h61, 8'h72, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h6B, 8'h65, 8'h72, 8'h6E, 8'h69, 8'h6E, 8'h67, 8'h73}
  };

endpackage

>>> rtl/core/tdt_lexer.sv
module tdt_lexer import tdt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] byte_in,
  output lex_out_t   lex_out
);

  mode_t       mode_r, mode_nxt;
  logic [30:0] acc_r, acc_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [5:0]  mask_r, mask_nxt;

  function automatic logic [5:0] kw_hit(input logic [7:0] pos, input logic [7:0] c);
    logic [5:0] hit;
    hit = '0;
    for (int k = 0; k < KW_COUNT; k++) begin
      hit[k] = (pos < {4'd0, KW_LEN[k]}) && (KW_TEXT[k][pos[2:0]] == c);
    end
    return hit;
  endfunction

  function automatic logic [2:0] kw_class(input logic [5:0] mask, input logic [7:0] len);
    logic [2:0] cls;
    cls = '0;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      if (mask[k] && (len == {4'd0, KW_LEN[k]})) begin
        cls = 3'(k + 1);
      end
    end
    return cls;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      acc_r  <= '0;
      len_r  <= '0;
      mask_r <= '1;
    end else if (step) begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
      len_r  <= len_nxt;
      mask_r <= mask_nxt;
    end
  end

  always_comb begin
    logic        is_num;
    logic        is_alpha;
    logic [7:0]  len_inc;
    logic [34:0] prod;
    logic        e0;
    logic        e1;
    logic        run_idle;
    logic        iemit;
    tok_t        tk0;
    tok_t        tk1;
    tok_t        itk;

    is_num   = (byte_in >= 8'h30) && (byte_in <= 8'h39);
    is_alpha = ((byte_in >= 8'h61) && (byte_in <= 8'h7A)) ||
               ((byte_in >= 8'h41) && (byte_in <= 8'h5A)) || (byte_in == CH_UNDER);
    len_inc  = (len_r == LEN_CAP) ? len_r : 8'(len_r + 8'd1);
    prod     = ({4'd0, acc_r} << 3) + ({4'd0, acc_r} << 1) + {31'd0, byte_in[3:0]};

    mode_nxt = mode_r;
    acc_nxt  = acc_r;
    len_nxt  = len_r;
    mask_nxt = mask_r;
    e0       = 1'b0;
    e1       = 1'b0;
    run_idle = 1'b0;
    iemit    = 1'b0;
    tk0      = '0;
    tk1      = '0;
    itk      = '0;

    case (mode_r)
      MODE_STR: begin
        if (byte_in == CH_QUOTE) begin
          e0 = 1'b1;
          tk0.kind = KIND_STRING;
          tk0.length = len_inc;
          mode_nxt = MODE_IDLE;
        end else if (byte_in == CH_EOF) begin
          e0 = 1'b1;
          tk0.kind = KIND_INVALID;
          tk0.length = len_r;
          e1 = 1'b1;
          tk1.kind = KIND_EOF;
          tk1.length = 8'd1;
          mode_nxt = MODE_IDLE;
        end else begin
          len_nxt = len_inc;
        end
      end
      MODE_ID: begin
        if (is_alpha || is_num) begin
          mask_nxt = mask_r & kw_hit(len_r, byte_in);
          len_nxt  = len_inc;
        end else begin
          e0 = 1'b1;
          tk0.kind = KIND_IDENT;
          tk0.length = len_r;
          tk0.kw_class = kw_class(mask_r, len_r);
          run_idle = 1'b1;
        end
      end
      MODE_INT: begin
        if (is_num) begin
          acc_nxt = (prod > {4'd0, INT_CAP}) ? INT_CAP : prod[30:0];
          len_nxt = len_inc;
        end else begin
          e0 = 1'b1;
          tk0.kind = KIND_INTEGER;
          tk0.int_value = acc_r;
          tk0.length = len_r;
          run_idle = 1'b1;
        end
      end
      default: begin
        run_idle = 1'b1;
      end
    endcase

    if (run_idle) begin
      mode_nxt   = MODE_IDLE;
      itk.length = 8'd1;
      if ((byte_in == CH_SPACE) || (byte_in == CH_NL)) begin
        iemit = 1'b0;
      end else if (byte_in == CH_QUOTE) begin
        mode_nxt = MODE_STR;
        len_nxt  = 8'd1;
      end else if (is_alpha) begin
        mode_nxt = MODE_ID;
        len_nxt  = 8'd1;
        mask_nxt = kw_hit(8'd0, byte_in);
      end else if (is_num) begin
        mode_nxt = MODE_INT;
        len_nxt  = 8'd1;
        acc_nxt  = {27'd0, byte_in[3:0]};
      end else begin
        iemit = 1'b1;
        case (byte_in)
          CH_EQ:    itk.kind = KIND_EQUALS;
          CH_MINUS: itk.kind = KIND_MINUS;
          CH_COMMA: itk.kind = KIND_COMMA;
          CH_EOF:   itk.kind = KIND_EOF;
          default:  itk.kind = KIND_INVALID;
        endcase
      end
      if (e0) begin
        tk1 = itk;
        e1  = iemit;
      end else begin
        tk0 = itk;
        e0  = iemit;
      end
    end

    if (e1) begin
      tk1.last = 1'b1;
    end else if (e0) begin
      tk0.last = 1'b1;
    end

    lex_out.count = {1'b0, e0} + {1'b0, e1};
    lex_out.tok0  = tk0;
    lex_out.tok1  = tk1;
  end

endmodule

>>> rtl/core/text_descriptor_tokenizer_top.sv
// output: tokens of an accepted byte are registered into the result queue and offered from its head
// throughput: one byte per cycle while the result queue holds at most one token;
// a byte that yields two tokens is drained as two transfers from a three-entry result queue
// reset: synchronous active-low rst_n returns the lexer to idle between tokens
// and empties the result queue
module text_descriptor_tokenizer_top import tdt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_token_kind,
  output logic [30:0] out_int_value,
  output logic [7:0]  out_token_length,
  output logic [2:0]  out_keyword_class,
  output logic        out_last_of_run
);

  lex_out_t   lex_out;
  logic       step;
  logic       pop;
  tok_t       q_r [3];
  tok_t       q_nxt [3];
  logic [1:0] cnt_r, cnt_nxt;

  assign in_ready  = (cnt_r <= 2'd1);
  assign step      = in_valid && in_ready;
  assign out_valid = (cnt_r != 2'd0);
  assign pop       = out_valid && out_ready;

  tdt_lexer u_lexer (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .byte_in (in_byte_in),
    .lex_out (lex_out)
  );

  always_comb begin
    logic [1:0] c;
    q_nxt = q_r;
    c     = cnt_r;
    if (pop) begin
      q_nxt[0] = q_r[1];
      q_nxt[1] = q_r[2];
      c = 2'(cnt_r - 2'd1);
    end
    if (step && (lex_out.count != 2'd0)) begin
      q_nxt[c] = lex_out.tok0;
      if (lex_out.count == 2'd2) begin
        q_nxt[2'(c + 2'd1)] = lex_out.tok1;
      end
    end
    cnt_nxt = step ? 2'(c + lex_out.count) : c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign out_token_kind    = q_r[0].kind;
  assign out_int_value     = q_r[0].int_value;
  assign out_token_length  = q_r[0].length;
  assign out_keyword_class = q_r[0].kw_class;
  assign out_last_of_run   = q_r[0].last;

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import tdt_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 300;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_byte_in;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_token_kind;
  logic [30:0] out_int_value;
  logic [7:0]  out_token_length;
  logic [2:0]  out_keyword_class;
  logic        out_last_of_run;

  text_descriptor_tokenizer_top u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_byte_in        (in_byte_in),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_token_kind    (out_token_kind),
    .out_int_value     (out_int_value),
    .out_token_length  (out_token_length),
    .out_keyword_class (out_keyword_class),
    .out_last_of_run   (out_last_of_run)
  );

  // lexer state mirror
  mode_t       lex_mode;
  logic [30:0] num_acc;
  logic [7:0]  tok_len;
  logic [5:0]  kw_alive;
  tok_t        step_tok [2];
  int          step_n;
  tok_t        pending_tokens [$];

  int  errors;
  int  cycle_cnt;
  int  bytes_sent;
  bit  tx_gaps_on;
  bit  rx_gaps_on;
  bit  hold_req;
  int  rx_wait;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic string kw_word(input int k);
    case (k)
      0: return "info";
      1: return "common";
      2: return "page";
      3: return "chars";
      4: return "char";
      5: return "kernings";
      default: return "";
    endcase
  endfunction

  function automatic bit is_num(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDER;
  endfunction

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic add_tok(input kind_t k, input logic [30:0] v, input logic [7:0] l,
                         input logic [2:0] w);
    step_tok[step_n] = '{kind: k, int_value: v, length: l, kw_class: w, last: 1'b0};
    step_n++;
  endtask

  task automatic bump_len();
    if (tok_len < LEN_CAP) tok_len++;
  endtask

  task automatic narrow_keywords(input logic [7:0] pos, input logic [7:0] c);
    string w;
    for (int k = 0; k < KW_COUNT; k++) begin
      w = kw_word(k);
      if (pos >= w.len()) kw_alive[k] = 1'b0;
      else if (w[pos] != c) kw_alive[k] = 1'b0;
    end
  endtask

  function automatic logic [2:0] keyword_hit();
    string w;
    for (int k = 0; k < KW_COUNT; k++) begin
      w = kw_word(k);
      if (kw_alive[k] && tok_len == w.len()) return 3'(k + 1);
    end
    return 3'd0;
  endfunction

  task automatic start_token(input logic [7:0] c);
    lex_mode = MODE_IDLE;
    if (c == CH_SPACE || c == CH_NL) begin
    end else if (c == CH_QUOTE) begin
      lex_mode = MODE_STR;
      tok_len = 8'd1;
    end else if (is_alpha(c)) begin
      lex_mode = MODE_ID;
      tok_len = 8'd1;
      kw_alive = 6'h3F;
      narrow_keywords(8'd0, c);
    end else if (is_num(c)) begin
      lex_mode = MODE_INT;
      tok_len = 8'd1;
      num_acc = 31'(c - "0");
    end else if (c == CH_EQ) add_tok(KIND_EQUALS, '0, 8'd1, '0);
    else if (c == CH_MINUS) add_tok(KIND_MINUS, '0, 8'd1, '0);
    else if (c == CH_COMMA) add_tok(KIND_COMMA, '0, 8'd1, '0);
    else if (c == CH_EOF) add_tok(KIND_EOF, '0, 8'd1, '0);
    else add_tok(KIND_INVALID, '0, 8'd1, '0);
  endtask

  task automatic lex_byte(input logic [7:0] c);
    logic [63:0] v;
    step_n = 0;
    case (lex_mode)
      MODE_STR: begin
        if (c == CH_QUOTE) begin
          bump_len();
          add_tok(KIND_STRING, '0, tok_len, '0);
          lex_mode = MODE_IDLE;
        end else if (c == CH_EOF) begin
          add_tok(KIND_INVALID, '0, tok_len, '0);
          add_tok(KIND_EOF, '0, 8'd1, '0);
          lex_mode = MODE_IDLE;
        end else begin
          bump_len();
        end
      end
      MODE_ID: begin
        if (is_alpha(c) || is_num(c)) begin
          narrow_keywords(tok_len, c);
          bump_len();
        end else begin
          add_tok(KIND_IDENT, '0, tok_len, keyword_hit());
          start_token(c);
        end
      end
      MODE_INT: begin
        if (is_num(c)) begin
          v = 64'(num_acc) * 64'd10 + 64'(c - "0");
          num_acc = (v > 64'(INT_CAP)) ? INT_CAP : v[30:0];
          bump_len();
        end else begin
          add_tok(KIND_INTEGER, num_acc, tok_len, '0);
          start_token(c);
        end
      end
      default: start_token(c);
    endcase
    if (step_n > 0) step_tok[step_n-1].last = 1'b1;
    for (int i = 0; i < step_n; i++) pending_tokens.push_back(step_tok[i]);
  endtask

  task automatic idle_cycles(input int n);
    if (n > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    in_valid   <= 1'b1;
    in_byte_in <= b;
    do @(posedge clk); while (!in_ready);
    lex_byte(b);
    bytes_sent++;
    if (tx_gaps_on) idle_cycles(rand_gap());
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  function automatic logic [7:0] pick_ident_char(input bit first);
    int r;
    r = first ? $urandom_range(0, 52) : $urandom_range(0, 63);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r < 62 && !first) return 8'("0" + r - 52);
    return CH_UNDER;
  endfunction

  function automatic logic [7:0] pick_string_char();
    logic [7:0] c;
    if ($urandom_range(0, 3) != 0) c = 8'($urandom_range(8'h20, 8'h7E));
    else c = 8'($urandom_range(1, 255));
    if (c == CH_QUOTE) c = "q";
    return c;
  endfunction

  task automatic send_ident();
    int n;
    n = $urandom_range(1, 7);
    send_byte(pick_ident_char(1'b1));
    repeat (n - 1) send_byte(pick_ident_char(1'b0));
  endtask

  task automatic send_number();
    int unsigned v;
    case ($urandom_range(0, 3))
      0: v = $urandom_range(0, 9);
      1: v = $urandom_range(10, 999);
      2: v = $urandom;
      default: v = $urandom_range(0, 65535);
    endcase
    send_str($sformatf("%0d", v));
    if ($urandom_range(0, 15) == 0) send_str("99999999999");
  endtask

  task automatic send_value();
    case ($urandom_range(0, 4))
      0: send_number();
      1: begin
        send_byte(CH_MINUS);
        send_number();
      end
      2: begin
        send_byte(CH_QUOTE);
        repeat ($urandom_range(0, 8)) send_byte(pick_string_char());
        send_byte(CH_QUOTE);
      end
      default: begin
        send_number();
        repeat ($urandom_range(1, 3)) begin
          send_byte(CH_COMMA);
          send_number();
        end
      end
    endcase
  endtask

  // one descriptor line, or noise, or a broken string
  task automatic send_record();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
    end else if (r == 1) begin
      send_byte(CH_QUOTE);
      repeat ($urandom_range(0, 5)) send_byte(pick_string_char());
      send_byte(CH_EOF);
    end else begin
      r = $urandom_range(0, 7);
      if (r < KW_COUNT) send_str(kw_word(r));
      else send_ident();
      repeat ($urandom_range(1, 4)) begin
        send_byte(CH_SPACE);
        send_ident();
        send_byte(CH_EQ);
        send_value();
      end
      send_byte(($urandom_range(0, 5) == 0) ? CH_SPACE : CH_NL);
      if ($urandom_range(0, 11) == 0) send_byte(CH_EOF);
    end
  endtask

  // receiver side
  initial begin
    out_ready = 1'b0;
    rx_wait   = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        rx_wait  = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (rx_wait > 0) begin
        out_ready <= 1'b0;
        rx_wait--;
      end else begin
        out_ready <= 1'b1;
        if (rx_gaps_on && $urandom_range(0, 3) == 0) rx_wait = rand_gap();
      end
    end
  end

  always @(posedge clk) begin : check_tokens
    tok_t got;
    tok_t want;
    if (rst_n && out_valid && out_ready) begin
      got = '{kind: kind_t'(out_token_kind), int_value: out_int_value,
              length: out_token_length, kw_class: out_keyword_class,
              last: out_last_of_run};
      if (pending_tokens.size() == 0) begin
        errors++;
        $display("%0t expected no token, actual kind %0d value %0d length %0d class %0d last %0b",
                 $time, got.kind, got.int_value, got.length, got.kw_class, got.last);
      end else begin
        want = pending_tokens.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t expected kind %0d value %0d length %0d class %0d last %0b",
                   $time, want.kind, want.int_value, want.length, want.kw_class, want.last);
          $display("%0t actual   kind %0d value %0d length %0d class %0d last %0b",
                   $time, got.kind, got.int_value, got.length, got.kw_class, got.last);
        end
      end
    end
  end

  task automatic test_single_bytes();
    send_byte(CH_EQ);
    send_byte(CH_MINUS);
    send_byte(CH_COMMA);
    send_byte(CH_SPACE);
    send_byte(CH_NL);
    send_byte(8'hFF);
    send_byte(8'h01);
    send_byte(8'h80);
    send_byte(8'h7F);
    send_byte(CH_EOF);
  endtask

  task automatic test_strings();
    send_str("\"\"");
    send_str("\"a b=,\"");
  endtask

  task automatic test_keywords();
    send_str("info common page chars char kernings ");
    send_str("Info cha charsx kerning _x9 a\n");
  endtask

  task automatic test_numbers();
    send_str("0 2147483647 2147483648 99999999999=");
    send_str("12a -7,");
  endtask

  task automatic test_eof_cases();
    send_str("\"abc");
    send_byte(CH_EOF);
    send_str("id");
    send_byte(CH_EOF);
    send_str("42");
    send_byte(CH_EOF);
    send_byte(CH_EOF);
    send_str("x\"q\"");
  endtask

  task automatic test_long_tokens();
    send_byte(CH_QUOTE);
    repeat (256) send_byte(pick_string_char());
    send_byte(CH_QUOTE);
  endtask

  task automatic test_backpressure();
    tx_gaps_on = 1'b0;
    hold_req   = 1'b1;
    repeat (10) send_str("a=");
    repeat (5) send_byte(CH_COMMA);
    tx_gaps_on = 1'b1;
  endtask

  task automatic test_random();
    int start;
    start = bytes_sent;
    while (bytes_sent - start < 40) begin
      tx_gaps_on = ($urandom_range(0, 4) != 0);
      rx_gaps_on = ($urandom_range(0, 4) != 0);
      send_record();
    end
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
  endtask

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_byte_in = 8'h00;
    errors     = 0;
    cycle_cnt  = 0;
    bytes_sent = 0;
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
    hold_req   = 1'b0;
    lex_mode   = MODE_IDLE;
    num_acc    = '0;
    tok_len    = '0;
    kw_alive   = 6'h3F;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_single_bytes();
    test_strings();
    test_keywords();
    test_numbers();
    test_eof_cases();
    test_long_tokens();
    test_backpressure();
    test_random();

    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending_tokens.size() == 0);
    repeat (10) @(posedge clk);
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
